// ===== rtl/pmid_pkg.sv =====
// Shared types and constants for the periodic minimum-image distance block.
package pmid_pkg;

    localparam int unsigned IDX_W      = 10;
    localparam int unsigned POS_W      = 16;
    localparam int unsigned BOX_W      = 24;
    localparam int unsigned DIST_W     = 24;
    localparam int unsigned SQ_W       = 2 * BOX_W;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned AXES       = 3;
    localparam int unsigned RESULT_LAT = 30;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BOX_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOX_Z = 2'd2;

    localparam logic [BOX_W-1:0] BOX_RESET = 24'd256;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
    } t_pos;

endpackage

// ===== rtl/pmid_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pmid_ram #(
    parameter int unsigned WIDTH = 48,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pmid_lane.sv =====
// One axis lane: wrapped separation, scaling by box edge, and squaring.
module pmid_lane (
    input  logic                          i_clk,
    input  logic [pmid_pkg::POS_W-1:0]    i_a,
    input  logic [pmid_pkg::POS_W-1:0]    i_b,
    input  logic [pmid_pkg::BOX_W-1:0]    i_box,
    output logic [pmid_pkg::SQ_W-1:0]     o_sq
);

    localparam int unsigned M_W    = pmid_pkg::POS_W + 1;
    localparam int unsigned PROD_W = M_W + pmid_pkg::BOX_W;
    localparam logic [M_W-1:0]    ONE  = M_W'(1) << pmid_pkg::POS_W;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (pmid_pkg::POS_W - 1);

    logic [pmid_pkg::POS_W-1:0] w_diff;
    logic [M_W-1:0]             n_m;
    logic [M_W-1:0]             r_m;
    logic [PROD_W-1:0]          w_prod;
    logic [pmid_pkg::BOX_W-1:0] r_comp;
    logic [pmid_pkg::SQ_W-1:0]  r_sq;

    always_comb begin
        w_diff = (i_a >= i_b) ? (i_a - i_b) : (i_b - i_a);
        n_m    = w_diff[pmid_pkg::POS_W-1] ? (ONE - M_W'(w_diff)) : M_W'(w_diff);
        w_prod = PROD_W'(r_m) * PROD_W'(i_box) + HALF;
    end

    always_ff @(posedge i_clk) begin
        r_m    <= n_m;
        r_comp <= w_prod[pmid_pkg::POS_W +: pmid_pkg::BOX_W];
        r_sq   <= r_comp * r_comp;
    end

    assign o_sq = r_sq;

endmodule

// ===== rtl/pmid_merge.sv =====
// Merge stage: sum of lane squares, pipelined square root, rounding and saturation.
module pmid_merge (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  logic [pmid_pkg::SQ_W-1:0]      i_sq [pmid_pkg::AXES],
    output logic                           o_done,
    output logic [pmid_pkg::DIST_W-1:0]    o_distance
);

    localparam int unsigned RT_W  = pmid_pkg::SQ_W / 2;
    localparam int unsigned REM_W = RT_W + 2;
    localparam int unsigned SUM_W = pmid_pkg::SQ_W + 2;

    logic [SUM_W-1:0]           w_sum;
    logic [pmid_pkg::SQ_W-1:0]  r_sum;
    logic                       r_sum_vld;

    logic [REM_W-1:0]           r_rem  [RT_W+1];
    logic [RT_W-1:0]            r_root [RT_W+1];
    logic [pmid_pkg::SQ_W-1:0]  r_rad  [RT_W+1];
    logic                       r_vld  [RT_W+1];

    logic [RT_W:0]              w_round;
    logic [pmid_pkg::DIST_W-1:0] r_distance;
    logic                       r_done;

    always_comb begin
        w_sum = SUM_W'(i_sq[0]) + SUM_W'(i_sq[1]) + SUM_W'(i_sq[2]);
        r_rem[0]  = '0;
        r_root[0] = '0;
        r_rad[0]  = r_sum;
        r_vld[0]  = r_sum_vld;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else begin
            r_sum_vld <= i_vld;
        end
        r_sum <= w_sum[pmid_pkg::SQ_W-1:0];
    end

    for (genvar g = 0; g < RT_W; g++) begin : g_root
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_trial;
        logic             w_ge;

        always_comb begin
            w_cur   = {r_rem[g][RT_W-1:0], r_rad[g][pmid_pkg::SQ_W-1 -: 2]};
            w_trial = {r_root[g], 2'b01};
            w_ge    = (w_cur >= w_trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else begin
                r_vld[g+1] <= r_vld[g];
            end
            r_rem[g+1]  <= w_ge ? (w_cur - w_trial) : w_cur;
            r_root[g+1] <= {r_root[g][RT_W-2:0], w_ge};
            r_rad[g+1]  <= {r_rad[g][pmid_pkg::SQ_W-3:0], 2'b00};
        end
    end

    always_comb begin
        w_round = (r_rem[RT_W] > REM_W'(r_root[RT_W])) ? ((RT_W+1)'(r_root[RT_W]) + 1'b1)
                                                       : (RT_W+1)'(r_root[RT_W]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[RT_W];
        end
        r_distance <= w_round[RT_W] ? '1 : w_round[pmid_pkg::DIST_W-1:0];
    end

    assign o_done     = r_done;
    assign o_distance = r_distance;

endmodule

// ===== rtl/periodic_min_image_distance.sv =====
// Top level: position store, three axis lanes and the merging square-root stage.
// Throughput: one item per cycle; busy stays low except during and right after reset.
// Both atoms are read in the same cycle from two mirrored copies of the position store.
// Reset (synchronous, active low) clears the pipeline and sets all box lengths to 1.0;
// the position store is not cleared. Results are strobed and cannot be stalled.
module periodic_min_image_distance #(
    parameter int unsigned ATOM_COUNT = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_command,
    input  logic [pmid_pkg::IDX_W-1:0]        i_first_index,
    input  logic [pmid_pkg::IDX_W-1:0]        i_second_index,
    input  logic [pmid_pkg::POS_W-1:0]        i_pos_x,
    input  logic [pmid_pkg::POS_W-1:0]        i_pos_y,
    input  logic [pmid_pkg::POS_W-1:0]        i_pos_z,
    input  logic                              i_cfg_we,
    input  logic [pmid_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [pmid_pkg::BOX_W-1:0]        i_cfg_data,
    output logic                              o_done,
    output logic [pmid_pkg::DIST_W-1:0]       o_distance
);

    localparam int unsigned AW    = $clog2(ATOM_COUNT);
    localparam int unsigned EXT_W = (AW > pmid_pkg::IDX_W) ? AW : pmid_pkg::IDX_W;
    localparam int unsigned POS_B = $bits(pmid_pkg::t_pos);

    logic                       r_busy;
    logic [pmid_pkg::BOX_W-1:0] r_box [pmid_pkg::AXES];

    logic                       w_accept;
    logic                       w_in_a;
    logic                       w_in_b;
    logic [EXT_W-1:0]           w_ext_a;
    logic [EXT_W-1:0]           w_ext_b;
    logic                       w_we;
    pmid_pkg::t_pos             w_wpos;
    logic [POS_B-1:0]           w_rd_a;
    logic [POS_B-1:0]           w_rd_b;
    pmid_pkg::t_pos             w_pa;
    pmid_pkg::t_pos             w_pb;

    logic                       r_in_a;
    logic                       r_in_b;
    logic [3:0]                 r_vld;

    logic [pmid_pkg::POS_W-1:0] w_a  [pmid_pkg::AXES];
    logic [pmid_pkg::POS_W-1:0] w_b  [pmid_pkg::AXES];
    logic [pmid_pkg::SQ_W-1:0]  w_sq [pmid_pkg::AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_box[0] <= pmid_pkg::BOX_RESET;
            r_box[1] <= pmid_pkg::BOX_RESET;
            r_box[2] <= pmid_pkg::BOX_RESET;
        end else begin
            r_busy <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pmid_pkg::REG_BOX_X: r_box[0] <= i_cfg_data;
                    pmid_pkg::REG_BOX_Y: r_box[1] <= i_cfg_data;
                    pmid_pkg::REG_BOX_Z: r_box[2] <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        w_accept = start && !r_busy;
        w_ext_a  = EXT_W'(i_first_index);
        w_ext_b  = EXT_W'(i_second_index);
        w_in_a   = (32'(i_first_index) < ATOM_COUNT);
        w_in_b   = (32'(i_second_index) < ATOM_COUNT);
        w_we     = w_accept && (i_command == pmid_pkg::CMD_WRITE) && w_in_a;
        w_wpos   = '{x: i_pos_x, y: i_pos_y, z: i_pos_z};
    end

    pmid_ram #(.WIDTH(POS_B), .DEPTH(ATOM_COUNT)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ext_a[AW-1:0]),
        .i_wdata (w_wpos),
        .i_raddr (w_ext_a[AW-1:0]),
        .o_rdata (w_rd_a)
    );

    pmid_ram #(.WIDTH(POS_B), .DEPTH(ATOM_COUNT)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_ext_a[AW-1:0]),
        .i_wdata (w_wpos),
        .i_raddr (w_ext_b[AW-1:0]),
        .o_rdata (w_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], w_accept && (i_command == pmid_pkg::CMD_QUERY)};
        end
        r_in_a <= w_in_a;
        r_in_b <= w_in_b;
    end

    always_comb begin
        w_pa = r_in_a ? pmid_pkg::t_pos'(w_rd_a) : '0;
        w_pb = r_in_b ? pmid_pkg::t_pos'(w_rd_b) : '0;
        w_a[0] = w_pa.x;
        w_a[1] = w_pa.y;
        w_a[2] = w_pa.z;
        w_b[0] = w_pb.x;
        w_b[1] = w_pb.y;
        w_b[2] = w_pb.z;
    end

    for (genvar g = 0; g < pmid_pkg::AXES; g++) begin : g_lane
        pmid_lane u_lane (
            .i_clk (i_clk),
            .i_a   (w_a[g]),
            .i_b   (w_b[g]),
            .i_box (r_box[g]),
            .o_sq  (w_sq[g])
        );
    end

    pmid_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_vld[3]),
        .i_sq       (w_sq),
        .o_done     (o_done),
        .o_distance (o_distance)
    );

    assign busy = r_busy;

endmodule

// ===== rtl/pmid_checker.sv =====
// Port-level checker for the distance block and its bind to the top level.
module pmid_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_done
);

    localparam int unsigned LAT = pmid_pkg::RESULT_LAT;

    logic [$clog2(LAT+1)-1:0] r_warm;
    logic                     w_query;

    assign w_query = start && !busy && (i_command == pmid_pkg::CMD_QUERY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= '0;
        end else if (r_warm != ($clog2(LAT+1))'(LAT)) begin
            r_warm <= r_warm + 1'b1;
        end
    end

    a_done_follows_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm == ($clog2(LAT+1))'(LAT)) |-> (o_done == $past(w_query, LAT)))
        else $error("result strobe does not match a query accepted earlier");

    a_no_early_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_warm != ($clog2(LAT+1))'(LAT)) |-> !o_done)
        else $error("result strobe before any query could complete");

    a_ready_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !busy)
        else $error("busy raised while running");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (busy && !o_done))
        else $error("block not quiet after reset");

endmodule

bind periodic_min_image_distance pmid_checker u_pmid_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_command (i_command),
    .o_done    (o_done)
);

// ===== tb/sv/tb_periodic_min_image_distance.sv =====
// Testbench for periodic_min_image_distance: random pos/box writes and distance queries
`timescale 1ns / 100ps

module tb_periodic_min_image_distance;

    localparam int unsigned ATOM_COUNT      = 1024;
    localparam int unsigned WATCHDOG_CYCLES = 2000;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned PHASE_ITEMS     = 75;
    localparam logic [pmid_pkg::CFG_IDX_W-1:0] REG_NONE = 2'd3;

    typedef enum logic [1:0] {K_ITEM, K_CFG, K_DRAIN} t_beat_kind;

    typedef struct {
        t_beat_kind                         kind;
        logic                               cmd;
        logic [pmid_pkg::IDX_W-1:0]         first;
        logic [pmid_pkg::IDX_W-1:0]         second;
        pmid_pkg::t_pos                     pos;
        logic [pmid_pkg::CFG_IDX_W-1:0]     reg_idx;
        logic [pmid_pkg::BOX_W-1:0]         reg_val;
    } t_pending_beat;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               i_command = pmid_pkg::CMD_WRITE;
    logic [pmid_pkg::IDX_W-1:0]         i_first_index = '0;
    logic [pmid_pkg::IDX_W-1:0]         i_second_index = '0;
    logic [pmid_pkg::POS_W-1:0]         i_pos_x = '0;
    logic [pmid_pkg::POS_W-1:0]         i_pos_y = '0;
    logic [pmid_pkg::POS_W-1:0]         i_pos_z = '0;
    logic                               i_cfg_we = 1'b0;
    logic [pmid_pkg::CFG_IDX_W-1:0]     i_cfg_idx = '0;
    logic [pmid_pkg::BOX_W-1:0]         i_cfg_data = '0;
    logic                               o_done;
    logic [pmid_pkg::DIST_W-1:0]        o_distance;

    t_pending_beat                      beat_q[$];
    logic [pmid_pkg::DIST_W-1:0]        want_dist_q[$];
    pmid_pkg::t_pos                     atom_mem[ATOM_COUNT];
    logic [pmid_pkg::BOX_W-1:0]         box_len[pmid_pkg::AXES];
    int                                 gen_written[$];
    logic                               beat_taken = 1'b0;
    int                                 quiet = 0;
    int                                 stall = 0;
    int                                 gap_left = 0;
    int                                 burst_left = 0;
    int                                 errors = 0;

    always #10 i_clk = ~i_clk;

    periodic_min_image_distance #(
        .ATOM_COUNT(ATOM_COUNT)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_command(i_command),
        .i_first_index(i_first_index),
        .i_second_index(i_second_index),
        .i_pos_x(i_pos_x),
        .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_done(o_done),
        .o_distance(o_distance)
    );

    function automatic logic [pmid_pkg::DIST_W-1:0] image_distance(input pmid_pkg::t_pos p,
                                                                   input pmid_pkg::t_pos q);
        logic [pmid_pkg::POS_W-1:0] a[pmid_pkg::AXES];
        logic [pmid_pkg::POS_W-1:0] b[pmid_pkg::AXES];
        logic [63:0] sep;
        logic [63:0] comp;
        logic [63:0] sum;
        logic [63:0] root;
        logic [63:0] trial;
        a = '{p.x, p.y, p.z};
        b = '{q.x, q.y, q.z};
        sum = '0;
        for (int k = 0; k < pmid_pkg::AXES; k++) begin
            sep = (a[k] >= b[k]) ? 64'(a[k] - b[k]) : 64'(b[k] - a[k]);
            if (sep > 64'd65536 - sep) begin
                sep = 64'd65536 - sep;
            end
            comp = (sep * 64'(box_len[k]) + 64'd32768) >> 16;
            sum += comp * comp;
        end
        root = '0;
        for (int j = 23; j >= 0; j--) begin
            trial = root | (64'd1 << j);
            if (trial * trial <= sum) begin
                root = trial;
            end
        end
        if (sum - root * root > root) begin
            root++;
        end
        if (root > 64'hFF_FFFF) begin
            root = 64'hFF_FFFF;
        end
        return root[pmid_pkg::DIST_W-1:0];
    endfunction

    function automatic logic [pmid_pkg::POS_W-1:0] pick_coord();
        logic [pmid_pkg::POS_W-1:0] edges[6] = '{16'h0000, 16'hFFFF, 16'h8000,
                                                 16'h7FFF, 16'h8001, 16'h0001};
        if ($urandom_range(0, 99) < 20) begin
            return edges[$urandom_range(0, 5)];
        end
        return pmid_pkg::POS_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [pmid_pkg::BOX_W-1:0] pick_box_len(input int mode);
        int r;
        r = $urandom_range(0, 9);
        if (mode == 0) begin
            return pmid_pkg::BOX_W'($urandom_range(0, 24'hFF_FFFF));
        end
        if (mode == 1) begin
            return pmid_pkg::BOX_RESET;
        end
        if (r == 0) begin
            return '0;
        end
        if (r == 1) begin
            return 24'hFF_FFFF;
        end
        if (r < 6) begin
            return pmid_pkg::BOX_W'($urandom_range(1, 4096));
        end
        return pmid_pkg::BOX_W'($urandom_range(0, 24'hFF_FFFF));
    endfunction

    function int pick_gap();
        int r;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 88) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 45);
    endfunction

    function void push_write(input logic [pmid_pkg::IDX_W-1:0] idx,
                             input logic [pmid_pkg::POS_W-1:0] x,
                             input logic [pmid_pkg::POS_W-1:0] y,
                             input logic [pmid_pkg::POS_W-1:0] z);
        t_pending_beat b;
        b = '{kind: K_ITEM, cmd: pmid_pkg::CMD_WRITE, first: idx,
              second: pmid_pkg::IDX_W'($urandom_range(0, 1023)), pos: '{x, y, z},
              reg_idx: '0, reg_val: '0};
        beat_q = {beat_q, b};
        gen_written = {gen_written, int'(idx)};
    endfunction

    function void push_query(input logic [pmid_pkg::IDX_W-1:0] first,
                             input logic [pmid_pkg::IDX_W-1:0] second);
        t_pending_beat b;
        b = '{kind: K_ITEM, cmd: pmid_pkg::CMD_QUERY, first: first, second: second,
              pos: '{pick_coord(), pick_coord(), pick_coord()},
              reg_idx: '0, reg_val: '0};
        beat_q = {beat_q, b};
    endfunction

    function void push_cfg(input logic [pmid_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pmid_pkg::BOX_W-1:0] val);
        t_pending_beat b;
        b = '{kind: K_CFG, cmd: pmid_pkg::CMD_WRITE, first: '0, second: '0, pos: '0,
              reg_idx: idx, reg_val: val};
        beat_q = {beat_q, b};
    endfunction

    function void push_drain();
        t_pending_beat b;
        b = '{kind: K_DRAIN, cmd: pmid_pkg::CMD_WRITE, first: '0, second: '0, pos: '0,
              reg_idx: '0, reg_val: '0};
        beat_q = {beat_q, b};
    endfunction

    function automatic logic [pmid_pkg::IDX_W-1:0] pick_written();
        if ($urandom_range(0, 3) == 0) begin
            return pmid_pkg::IDX_W'(gen_written[gen_written.size() - 1]);
        end
        return pmid_pkg::IDX_W'(gen_written[$urandom_range(0, gen_written.size() - 1)]);
    endfunction

    always @(negedge i_clk) begin : driver
        t_pending_beat head;
        logic nx_start;
        logic nx_we;
        nx_start = start;
        nx_we = 1'b0;
        if (i_rst_n && !(start && !beat_taken)) begin
            nx_start = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (beat_q.size() != 0) begin
                head = beat_q[0];
                case (head.kind)
                    K_ITEM: begin
                        void'(beat_q.pop_front());
                        i_command <= head.cmd;
                        i_first_index <= head.first;
                        i_second_index <= head.second;
                        i_pos_x <= head.pos.x;
                        i_pos_y <= head.pos.y;
                        i_pos_z <= head.pos.z;
                        nx_start = 1'b1;
                        gap_left = pick_gap();
                    end
                    K_DRAIN: begin
                        if (want_dist_q.size() == 0) begin
                            void'(beat_q.pop_front());
                        end
                    end
                    default: begin
                        if (want_dist_q.size() == 0 && quiet >= pmid_pkg::RESULT_LAT + 4) begin
                            void'(beat_q.pop_front());
                            nx_we = 1'b1;
                            i_cfg_idx <= head.reg_idx;
                            i_cfg_data <= head.reg_val;
                        end
                    end
                endcase
            end
        end
        start <= nx_start;
        i_cfg_we <= nx_we;
    end

    always @(posedge i_clk) begin : monitor
        logic in_beat;
        logic [pmid_pkg::DIST_W-1:0] want;
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
            quiet <= 0;
            stall <= 0;
        end else begin
            in_beat = start && !busy;
            beat_taken <= in_beat;
            quiet <= in_beat ? 0 : quiet + 1;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pmid_pkg::REG_BOX_X: box_len[0] = i_cfg_data;
                    pmid_pkg::REG_BOX_Y: box_len[1] = i_cfg_data;
                    pmid_pkg::REG_BOX_Z: box_len[2] = i_cfg_data;
                    default: ;
                endcase
            end
            if (in_beat) begin
                if (i_command == pmid_pkg::CMD_WRITE) begin
                    atom_mem[i_first_index] = '{i_pos_x, i_pos_y, i_pos_z};
                end else begin
                    want = image_distance(atom_mem[i_first_index], atom_mem[i_second_index]);
                    want_dist_q = {want_dist_q, want};
                end
            end
            if (o_done) begin
                if (want_dist_q.size() == 0) begin
                    $display("%0t: unexpected distance beat: expected none, actual %h",
                             $time, o_distance);
                    errors++;
                end else begin
                    want = want_dist_q.pop_front();
                    if (o_distance !== want) begin
                        $display("%0t: distance mismatch: expected %h, actual %h",
                                 $time, want, o_distance);
                        errors++;
                    end
                end
            end
            if (in_beat || o_done || i_cfg_we) begin
                stall <= 0;
            end else if (stall >= WATCHDOG_CYCLES) begin
                $display("FAIL periodic_min_image_distance");
                $finish;
            end else begin
                stall <= stall + 1;
            end
        end
    end

    initial begin : stimulus
        for (int k = 0; k < pmid_pkg::AXES; k++) begin
            box_len[k] = pmid_pkg::BOX_RESET;
        end

        push_write(10'd0, 16'h0000, 16'h0000, 16'h0000);
        push_write(10'd1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_write(10'd1, 16'h8000, 16'h8000, 16'h8000);
        push_write(10'd2, 16'h7FFF, 16'h8001, 16'h0001);
        push_write(10'd3, 16'hAAAA, 16'h5555, 16'h1234);
        push_query(10'd0, 10'd0);
        push_query(10'd0, 10'd1023);
        push_query(10'd1023, 10'd0);
        push_query(10'd0, 10'd1);
        push_query(10'd1, 10'd2);
        push_query(10'd2, 10'd3);
        push_write(10'd4, 16'h0100, 16'hFF00, 16'h0F0F);
        push_query(10'd4, 10'd0);
        push_write(10'd4, 16'hF0F0, 16'h00FF, 16'h8000);
        push_query(10'd0, 10'd4);
        push_query(10'd4, 10'd4);
        push_drain();
        push_cfg(pmid_pkg::REG_BOX_X, 24'h00_0000);
        push_cfg(pmid_pkg::REG_BOX_Y, 24'hFF_FFFF);
        push_cfg(pmid_pkg::REG_BOX_Z, 24'h01_2345);
        push_cfg(REG_NONE, 24'hFF_FFFF);
        push_query(10'd0, 10'd1);
        push_query(10'd1, 10'd1023);
        push_query(10'd2, 10'd3);
        push_cfg(pmid_pkg::REG_BOX_X, 24'hFF_FFFF);
        push_cfg(pmid_pkg::REG_BOX_Z, 24'hFF_FFFF);
        push_query(10'd0, 10'd1);
        push_query(10'd3, 10'd1023);
        push_query(10'd1023, 10'd3);

        for (int ph = 0; ph < PHASES; ph++) begin
            push_cfg(pmid_pkg::REG_BOX_X, pick_box_len(ph));
            push_cfg(pmid_pkg::REG_BOX_Y, pick_box_len(ph));
            push_cfg(pmid_pkg::REG_BOX_Z, pick_box_len(ph));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(0, 39) == 0) begin
                    push_drain();
                end
                if ($urandom_range(0, 99) < 35) begin
                    push_write($urandom_range(0, 99) < 60
                                   ? pmid_pkg::IDX_W'($urandom_range(0, 1023))
                                   : pick_written(),
                               pick_coord(), pick_coord(), pick_coord());
                end else begin
                    push_query(pick_written(), pick_written());
                end
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (beat_q.size() != 0 || start || want_dist_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (pmid_pkg::RESULT_LAT + 8) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS periodic_min_image_distance");
        end else begin
            $display("FAIL periodic_min_image_distance");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pmid_pkg.sv
rtl/pmid_ram.sv
rtl/pmid_lane.sv
rtl/pmid_merge.sv
rtl/periodic_min_image_distance.sv
rtl/pmid_checker.sv
tb/sv/tb_periodic_min_image_distance.sv
